@@ hw/rtl/gbnq_pkg.sv @@
package gbnq_pkg;

  localparam int GRID_W      = 64;
  localparam int GRID_H      = 64;
  localparam int NUM_OBJECTS = 1024;
  localparam int MAX_REACH   = 28;
  localparam int MAX_RESULTS = 64;

  localparam int NODE_COUNT = NUM_OBJECTS + GRID_W * GRID_H;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int XW         = (GRID_W > 1) ? $clog2(GRID_W) : 1;
  localparam int YW         = (GRID_H > 1) ? $clog2(GRID_H) : 1;

  // signed cell offset and chebyshev ring index
  localparam int OFS_W  = $clog2(MAX_REACH + 1) + 1;
  localparam int CH_W   = $clog2(MAX_REACH + 2);
  localparam int MAX_D2 = 2 * MAX_REACH * MAX_REACH;
  localparam int D2_W   = $clog2(MAX_D2 + 2);
  localparam int LIM_W  = 17;

  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_MOVE   = 2'd0;
  localparam opcode_t OP_REMOVE = 2'd1;
  localparam opcode_t OP_QUERY  = 2'd2;

  localparam logic [1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_WRAP_MODE   = 2'd2;

  typedef struct packed {
    logic init;
    logic adv;
  } ofs_ctl_t;

  typedef struct packed {
    logic                    vld;
    logic                    done;
    logic signed [OFS_W-1:0] dx;
    logic signed [OFS_W-1:0] dy;
  } ofs_sts_t;

endpackage

@@ hw/rtl/grid_bucket_neighbor_query_top.sv @@
// move and remove unlink in U0, U1, U2, a move into the grid relinks in M1, M2; FIN gives the single acknowledgement
// a query scans the offset table by (distance, ring) candidate, visits each cell in range
// and lists its objects up to the cap; its last result ends the item
// one item at a time: busy falls in the cycle that shows the last result
// after reset the link memories are swept, one node a cycle, all 5120 nodes, while busy
// results are shown for one cycle on out_valid; the receiver cannot stall
module grid_bucket_neighbor_query_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_opcode,
  input  logic [9:0]        in_object_id,
  input  logic signed [9:0] in_cell_x,
  input  logic signed [9:0] in_cell_y,
  input  logic [7:0]        in_search_range,
  input  logic [6:0]        in_max_found,
  output logic              out_valid,
  output logic [9:0]        out_found_id,
  output logic              out_none_found,
  output logic              out_last,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [6:0]        cfg_wdata
);

  localparam int NW = gbnq_pkg::NODE_W;

  typedef enum logic [10:0] {
    S_CLR  = 11'b00000000001,
    S_IDLE = 11'b00000000010,
    S_U0   = 11'b00000000100,
    S_U1   = 11'b00000001000,
    S_U2   = 11'b00000010000,
    S_M1   = 11'b00000100000,
    S_M2   = 11'b00001000000,
    S_QPT  = 11'b00010000000,
    S_QADR = 11'b00100000000,
    S_WALK = 11'b01000000000,
    S_FIN  = 11'b10000000000
  } st_t;

  st_t st_r, st_nxt;

  logic [6:0] gw_r, gh_r;
  logic       wrap_r;

  gbnq_pkg::opcode_t          op_r, op_nxt;
  logic [9:0]                 id_r, id_nxt;
  logic signed [9:0]          cx_r, cx_nxt, cy_r, cy_nxt;
  logic [6:0]                 cap_r, cap_nxt;
  logic [gbnq_pkg::LIM_W-1:0] limit_r, limit_nxt;
  logic [NW-1:0]              clr_r, clr_nxt;
  logic [NW-1:0]              head_r, head_nxt;
  logic [NW-1:0]              first_r, first_nxt;
  logic [6:0]                 cnt_r, cnt_nxt;
  logic                       pend_vld_r, pend_vld_nxt;
  logic [9:0]                 pend_id_r, pend_id_nxt;
  logic signed [gbnq_pkg::OFS_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic                       ov_r, ov_nxt;
  logic [9:0]                 oid_r, oid_nxt;
  logic                       onone_r, onone_nxt;
  logic                       olast_r, olast_nxt;

  logic          nxt_we, prv_we;
  logic [NW-1:0] nxt_waddr, nxt_wdata, nxt_raddr, nxt_q;
  logic [NW-1:0] prv_waddr, prv_wdata, prv_raddr, prv_q;

  gbnq_pkg::ofs_ctl_t ofs_ctl;
  gbnq_pkg::ofs_sts_t ofs_sts;

  logic [6:0] ew, eh, rch_r, rch_l, rch_u, rch_d;
  logic [6:0] in_cap;
  logic       accept;

  function automatic logic [6:0] reach_clip(input logic [6:0] v);
    reach_clip = (v > 7'(gbnq_pkg::MAX_REACH)) ? 7'(gbnq_pkg::MAX_REACH) : v;
  endfunction

  // clamped grid size and reach of the offset table
  always_comb begin
    ew = (gw_r == '0) ? 7'd1 : ((gw_r > 7'(gbnq_pkg::GRID_W)) ? 7'(gbnq_pkg::GRID_W) : gw_r);
    eh = (gh_r == '0) ? 7'd1 : ((gh_r > 7'(gbnq_pkg::GRID_H)) ? 7'(gbnq_pkg::GRID_H) : gh_r);
    if (wrap_r) begin
      rch_r = reach_clip(ew >> 1);
      rch_l = reach_clip((ew - 7'd1) >> 1);
      rch_u = reach_clip(eh >> 1);
      rch_d = reach_clip((eh - 7'd1) >> 1);
    end else begin
      rch_r = reach_clip(ew - 7'd1);
      rch_l = reach_clip(ew - 7'd1);
      rch_u = reach_clip(eh - 7'd1);
      rch_d = reach_clip(eh - 7'd1);
    end
  end

  assign busy   = (st_r != S_IDLE);
  assign accept = start && !busy;
  assign in_cap = (in_max_found > 7'(gbnq_pkg::MAX_RESULTS)) ?
                  7'(gbnq_pkg::MAX_RESULTS) : in_max_found;

  // move target cell
  logic signed [10:0] we_s, he_s;
  logic               mv_in_grid;
  logic [NW-1:0]      head_mv;

  assign we_s = $signed({4'b0, ew});
  assign he_s = $signed({4'b0, eh});
  assign mv_in_grid = (cx_r >= 0) && ($signed({cx_r[9], cx_r}) < we_s) &&
                      (cy_r >= 0) && ($signed({cy_r[9], cy_r}) < he_s);
  assign head_mv = NW'(gbnq_pkg::NUM_OBJECTS) +
                   NW'(cx_r[gbnq_pkg::XW-1:0]) * NW'(gbnq_pkg::GRID_H) +
                   NW'(cy_r[gbnq_pkg::YW-1:0]);

  // query cell: table clip, then one wrap, then grid check
  logic signed [7:0]  dxe, dye;
  logic signed [10:0] xs, ys, xa, ya;
  logic               in_tbl, x_skip, y_skip, cell_ok;
  logic [NW-1:0]      head_q;

  always_comb begin
    dxe = {{(8 - gbnq_pkg::OFS_W){dx_r[gbnq_pkg::OFS_W-1]}}, dx_r};
    dye = {{(8 - gbnq_pkg::OFS_W){dy_r[gbnq_pkg::OFS_W-1]}}, dy_r};
    in_tbl = (dxe >= -$signed({1'b0, rch_l})) && (dxe <= $signed({1'b0, rch_r})) &&
             (dye >= -$signed({1'b0, rch_d})) && (dye <= $signed({1'b0, rch_u}));
    xs = $signed({cx_r[9], cx_r}) + $signed({{3{dxe[7]}}, dxe});
    ys = $signed({cy_r[9], cy_r}) + $signed({{3{dye[7]}}, dye});
    x_skip = 1'b0;
    y_skip = 1'b0;
    if (xs < 0) begin
      x_skip = !wrap_r;
      xa     = xs + we_s;
    end else if (xs >= we_s) begin
      x_skip = !wrap_r;
      xa     = xs - we_s;
    end else begin
      xa = xs;
    end
    if (ys < 0) begin
      y_skip = !wrap_r;
      ya     = ys + he_s;
    end else if (ys >= he_s) begin
      y_skip = !wrap_r;
      ya     = ys - he_s;
    end else begin
      ya = ys;
    end
    cell_ok = in_tbl && !x_skip && !y_skip &&
              (xa >= 0) && (xa < we_s) && (ya >= 0) && (ya < he_s);
    head_q = NW'(gbnq_pkg::NUM_OBJECTS) +
             NW'(xa[gbnq_pkg::XW-1:0]) * NW'(gbnq_pkg::GRID_H) +
             NW'(ya[gbnq_pkg::YW-1:0]);
  end

  logic [6:0] cnt_inc;
  logic       walk_hit;

  assign cnt_inc  = cnt_r + 7'd1;
  assign walk_hit = (nxt_q != head_r) && (nxt_q < NW'(gbnq_pkg::NUM_OBJECTS));

  always_comb begin
    st_nxt       = st_r;
    op_nxt       = op_r;
    id_nxt       = id_r;
    cx_nxt       = cx_r;
    cy_nxt       = cy_r;
    cap_nxt      = cap_r;
    limit_nxt    = limit_r;
    clr_nxt      = clr_r;
    head_nxt     = head_r;
    first_nxt    = first_r;
    cnt_nxt      = cnt_r;
    pend_vld_nxt = pend_vld_r;
    pend_id_nxt  = pend_id_r;
    dx_nxt       = dx_r;
    dy_nxt       = dy_r;
    ov_nxt       = 1'b0;
    oid_nxt      = oid_r;
    onone_nxt    = onone_r;
    olast_nxt    = olast_r;
    nxt_we       = 1'b0;
    prv_we       = 1'b0;
    nxt_waddr    = clr_r;
    nxt_wdata    = clr_r;
    prv_waddr    = clr_r;
    prv_wdata    = clr_r;
    nxt_raddr    = NW'(id_r);
    prv_raddr    = NW'(id_r);
    ofs_ctl      = '0;

    case (st_r)
      S_CLR: begin
        nxt_we  = 1'b1;
        prv_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == NW'(gbnq_pkg::NODE_COUNT - 1)) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_opcode;
          id_nxt    = in_object_id;
          cx_nxt    = in_cell_x;
          cy_nxt    = in_cell_y;
          cap_nxt   = in_cap;
          limit_nxt = gbnq_pkg::LIM_W'({16'(in_search_range) * 16'(in_search_range), 1'b0});
          cnt_nxt   = '0;
          pend_vld_nxt = 1'b0;
          if (in_opcode == gbnq_pkg::OP_QUERY) begin
            if (in_cap == '0) begin
              st_nxt = S_FIN;
            end else begin
              ofs_ctl.init = 1'b1;
              st_nxt       = S_QPT;
            end
          end else if ((in_opcode == gbnq_pkg::OP_MOVE || in_opcode == gbnq_pkg::OP_REMOVE) &&
                       (NW'(in_object_id) < NW'(gbnq_pkg::NUM_OBJECTS))) begin
            st_nxt = S_U0;
          end else begin
            st_nxt = S_FIN;
          end
        end
      end
      S_U0: begin
        st_nxt = S_U1;
      end
      S_U1: begin
        // bridge the neighbours over the object
        if (nxt_q < NW'(gbnq_pkg::NODE_COUNT) && prv_q < NW'(gbnq_pkg::NODE_COUNT)) begin
          prv_we    = 1'b1;
          prv_waddr = nxt_q;
          prv_wdata = prv_q;
          nxt_we    = 1'b1;
          nxt_waddr = prv_q;
          nxt_wdata = nxt_q;
        end
        st_nxt = S_U2;
      end
      S_U2: begin
        nxt_we    = 1'b1;
        nxt_waddr = NW'(id_r);
        nxt_wdata = NW'(id_r);
        prv_we    = 1'b1;
        prv_waddr = NW'(id_r);
        prv_wdata = NW'(id_r);
        nxt_raddr = head_mv;
        if (op_r == gbnq_pkg::OP_MOVE && mv_in_grid) begin
          st_nxt = S_M1;
        end else begin
          st_nxt = S_FIN;
        end
      end
      S_M1: begin
        first_nxt = nxt_q;
        nxt_we    = 1'b1;
        nxt_waddr = NW'(id_r);
        nxt_wdata = nxt_q;
        prv_we    = 1'b1;
        prv_waddr = NW'(id_r);
        prv_wdata = head_mv;
        st_nxt    = S_M2;
      end
      S_M2: begin
        prv_we    = (first_r < NW'(gbnq_pkg::NODE_COUNT));
        prv_waddr = first_r;
        prv_wdata = NW'(id_r);
        nxt_we    = 1'b1;
        nxt_waddr = head_mv;
        nxt_wdata = NW'(id_r);
        st_nxt    = S_FIN;
      end
      S_QPT: begin
        if (ofs_sts.vld) begin
          dx_nxt      = ofs_sts.dx;
          dy_nxt      = ofs_sts.dy;
          ofs_ctl.adv = 1'b1;
          st_nxt      = S_QADR;
        end else if (ofs_sts.done) begin
          st_nxt = S_FIN;
        end
      end
      S_QADR: begin
        nxt_raddr = head_q;
        head_nxt  = head_q;
        st_nxt    = cell_ok ? S_WALK : S_QPT;
      end
      S_WALK: begin
        nxt_raddr = nxt_q;
        if (walk_hit) begin
          // hold one id back so the final one can carry last
          if (pend_vld_r) begin
            ov_nxt    = 1'b1;
            oid_nxt   = pend_id_r;
            onone_nxt = 1'b0;
            olast_nxt = 1'b0;
          end
          pend_vld_nxt = 1'b1;
          pend_id_nxt  = nxt_q[9:0];
          cnt_nxt      = cnt_inc;
          if (cnt_inc == cap_r) begin
            st_nxt = S_FIN;
          end
        end else begin
          st_nxt = S_QPT;
        end
      end
      S_FIN: begin
        ov_nxt       = 1'b1;
        oid_nxt      = pend_vld_r ? pend_id_r : '0;
        onone_nxt    = !pend_vld_r;
        olast_nxt    = 1'b1;
        pend_vld_nxt = 1'b0;
        st_nxt       = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_CLR;
      clr_r      <= '0;
      cnt_r      <= '0;
      pend_vld_r <= 1'b0;
      ov_r       <= 1'b0;
      gw_r       <= 7'd64;
      gh_r       <= 7'd64;
      wrap_r     <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      clr_r      <= clr_nxt;
      cnt_r      <= cnt_nxt;
      pend_vld_r <= pend_vld_nxt;
      ov_r       <= ov_nxt;
      if (cfg_we) begin
        case (cfg_index)
          gbnq_pkg::CFG_GRID_WIDTH:  gw_r   <= cfg_wdata;
          gbnq_pkg::CFG_GRID_HEIGHT: gh_r   <= cfg_wdata;
          gbnq_pkg::CFG_WRAP_MODE:   wrap_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
    op_r      <= op_nxt;
    id_r      <= id_nxt;
    cx_r      <= cx_nxt;
    cy_r      <= cy_nxt;
    cap_r     <= cap_nxt;
    limit_r   <= limit_nxt;
    head_r    <= head_nxt;
    first_r   <= first_nxt;
    pend_id_r <= pend_id_nxt;
    dx_r      <= dx_nxt;
    dy_r      <= dy_nxt;
    oid_r     <= oid_nxt;
    onone_r   <= onone_nxt;
    olast_r   <= olast_nxt;
  end

  gbnq_ram #(
    .DEPTH (gbnq_pkg::NODE_COUNT),
    .WIDTH (NW)
  ) u_next_ram (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr),
    .wdata (nxt_wdata),
    .raddr (nxt_raddr),
    .rdata (nxt_q)
  );

  gbnq_ram #(
    .DEPTH (gbnq_pkg::NODE_COUNT),
    .WIDTH (NW)
  ) u_prev_ram (
    .clk   (clk),
    .we    (prv_we),
    .waddr (prv_waddr),
    .wdata (prv_wdata),
    .raddr (prv_raddr),
    .rdata (prv_q)
  );

  gbnq_ofs u_ofs (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ofs_ctl),
    .limit (limit_r),
    .sts   (ofs_sts)
  );

  assign out_valid      = ov_r;
  assign out_found_id   = oid_r;
  assign out_none_found = onone_r;
  assign out_last       = olast_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("transfer accepted but block not busy");

  a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_FIN) |=> (out_valid && out_last))
    else $error("item closed without a last result");

  a_none_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_none_found) |-> (out_last && out_found_id == '0))
    else $error("empty result not a closing acknowledgement");

  a_walk_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_WALK) |-> (cnt_r < cap_r))
    else $error("list walk beyond the result cap");

  a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    nxt_we |-> (nxt_waddr < NW'(gbnq_pkg::NODE_COUNT)))
    else $error("link write outside node range");

endmodule

@@ hw/rtl/gbnq_ram.sv @@
module gbnq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/gbnq_ofs.sv @@
module gbnq_ofs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gbnq_pkg::ofs_ctl_t            ctl,
  input  logic [gbnq_pkg::LIM_W-1:0]    limit,
  output gbnq_pkg::ofs_sts_t            sts
);

  typedef enum logic [2:0] {
    O_SCAN = 3'b001,
    O_HOLD = 3'b010,
    O_DONE = 3'b100
  } ost_t;

  ost_t                          ost_r, ost_nxt;
  logic [gbnq_pkg::D2_W-1:0]     d2_r, d2_nxt;
  logic [gbnq_pkg::CH_W-1:0]     c_r, c_nxt;
  logic [gbnq_pkg::CH_W-1:0]     clo_r, clo_nxt;
  logic [gbnq_pkg::CH_W-1:0]     m_r, m_nxt;
  logic [2:0]                    pt_r, pt_nxt;

  logic [2*gbnq_pkg::CH_W-1:0]   csq, closq;
  logic [gbnq_pkg::D2_W-1:0]     d2_inc, t_rem;
  logic                          sq_hit;
  logic [gbnq_pkg::CH_W-1:0]     sq_root;
  logic [3:0]                    npt;
  logic signed [gbnq_pkg::OFS_W-1:0] cs, ms, dx, dy;

  assign csq    = c_r * c_r;
  assign closq  = clo_r * clo_r;
  assign d2_inc = d2_r + 1'b1;
  assign t_rem  = d2_r - gbnq_pkg::D2_W'(csq);

  // exact root of the remainder against the constant squares
  always_comb begin
    sq_hit  = 1'b0;
    sq_root = '0;
    for (int k = 0; k <= gbnq_pkg::MAX_REACH; k++) begin
      if (gbnq_pkg::D2_W'(k * k) == t_rem) begin
        sq_hit  = 1'b1;
        sq_root = gbnq_pkg::CH_W'(k);
      end
    end
  end

  assign cs = $signed(gbnq_pkg::OFS_W'(c_r));
  assign ms = $signed(gbnq_pkg::OFS_W'(m_r));

  // points of one (distance, ring) group, row order
  always_comb begin
    dx  = '0;
    dy  = '0;
    npt = 4'd8;
    if (c_r == '0) begin
      npt = 4'd1;
    end else if (m_r == c_r) begin
      npt = 4'd4;
      dx  = pt_r[0] ? cs : -cs;
      dy  = pt_r[1] ? cs : -cs;
    end else if (m_r == '0) begin
      npt = 4'd4;
      case (pt_r[1:0])
        2'd0: begin dx = '0;  dy = -cs; end
        2'd1: begin dx = -cs; dy = '0;  end
        2'd2: begin dx = cs;  dy = '0;  end
        default: begin dx = '0; dy = cs; end
      endcase
    end else begin
      case (pt_r)
        3'd0: begin dx = -ms; dy = -cs; end
        3'd1: begin dx = ms;  dy = -cs; end
        3'd2: begin dx = -cs; dy = -ms; end
        3'd3: begin dx = cs;  dy = -ms; end
        3'd4: begin dx = -cs; dy = ms;  end
        3'd5: begin dx = cs;  dy = ms;  end
        3'd6: begin dx = -ms; dy = cs;  end
        default: begin dx = ms; dy = cs; end
      endcase
    end
  end

  always_comb begin
    ost_nxt = ost_r;
    d2_nxt  = d2_r;
    c_nxt   = c_r;
    clo_nxt = clo_r;
    m_nxt   = m_r;
    pt_nxt  = pt_r;
    if (ctl.init) begin
      ost_nxt = O_SCAN;
      d2_nxt  = '0;
      c_nxt   = '0;
      clo_nxt = '0;
    end else begin
      case (ost_r)
        O_SCAN: begin
          if (gbnq_pkg::LIM_W'(d2_r) > limit || d2_r > gbnq_pkg::D2_W'(gbnq_pkg::MAX_D2)) begin
            ost_nxt = O_DONE;
          end else if (c_r > gbnq_pkg::CH_W'(gbnq_pkg::MAX_REACH) ||
                       gbnq_pkg::D2_W'(csq) > d2_r) begin
            // ring window slides up with the distance
            d2_nxt = d2_inc;
            if (gbnq_pkg::D2_W'({closq, 1'b0}) < d2_inc) begin
              clo_nxt = clo_r + 1'b1;
              c_nxt   = clo_r + 1'b1;
            end else begin
              c_nxt = clo_r;
            end
          end else if (sq_hit) begin
            m_nxt   = sq_root;
            pt_nxt  = '0;
            ost_nxt = O_HOLD;
          end else begin
            c_nxt = c_r + 1'b1;
          end
        end
        O_HOLD: begin
          if (ctl.adv) begin
            if (4'(pt_r) + 4'd1 == npt) begin
              c_nxt   = c_r + 1'b1;
              ost_nxt = O_SCAN;
            end else begin
              pt_nxt = pt_r + 1'b1;
            end
          end
        end
        O_DONE: begin
          ost_nxt = O_DONE;
        end
        default: begin
          ost_nxt = O_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ost_r <= O_DONE;
    end else begin
      ost_r <= ost_nxt;
    end
    d2_r  <= d2_nxt;
    c_r   <= c_nxt;
    clo_r <= clo_nxt;
    m_r   <= m_nxt;
    pt_r  <= pt_nxt;
  end

  assign sts.vld  = (ost_r == O_HOLD);
  assign sts.done = (ost_r == O_DONE);
  assign sts.dx   = dx;
  assign sts.dy   = dy;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam gbnq_pkg::opcode_t OP_SPARE = 2'd3;
  localparam int TBL_SPAN = 2 * gbnq_pkg::MAX_REACH + 1;
  localparam int TBL_MAX = TBL_SPAN * TBL_SPAN;
  localparam int STALL_LIMIT = 400000;

  typedef struct {
    logic [9:0] found_id;
    logic       none_found;
    logic       last;
  } hit_t;

  class neighbour_scoreboard;
    int nxt[gbnq_pkg::NODE_COUNT];
    int prv[gbnq_pkg::NODE_COUNT];
    int width_reg, height_reg, wrap_reg;
    int ofs_dx[TBL_MAX];
    int ofs_dy[TBL_MAX];
    int ofs_key[TBL_MAX];
    int ofs_len;
    bit ofs_stale;
    hit_t pending[$];
    int errors;

    function void clear_state();
      for (int i = 0; i < gbnq_pkg::NODE_COUNT; i++) begin
        nxt[i] = i;
        prv[i] = i;
      end
      width_reg = 64;
      height_reg = 64;
      wrap_reg = 0;
      ofs_stale = 1;
      errors = 0;
    endfunction

    function void configure(logic [1:0] idx, logic [6:0] val);
      if (idx == gbnq_pkg::CFG_GRID_WIDTH) width_reg = val;
      else if (idx == gbnq_pkg::CFG_GRID_HEIGHT) height_reg = val;
      else if (idx == gbnq_pkg::CFG_WRAP_MODE) wrap_reg = val[0];
      else return;
      ofs_stale = 1;
    endfunction

    function int eff_w();
      return width_reg < 1 ? 1 :
             (width_reg > gbnq_pkg::GRID_W ? gbnq_pkg::GRID_W : width_reg);
    endfunction

    function int eff_h();
      return height_reg < 1 ? 1 :
             (height_reg > gbnq_pkg::GRID_H ? gbnq_pkg::GRID_H : height_reg);
    endfunction

    function int reach(int v);
      return v < gbnq_pkg::MAX_REACH ? v : gbnq_pkg::MAX_REACH;
    endfunction

    // offsets sorted by squared distance, then ring, then row order
    function void sort_offsets();
      int w, h, rt, lf, up, dn, k, j, ax, ay;
      w = eff_w();
      h = eff_h();
      if (wrap_reg) begin
        rt = reach(w / 2); lf = reach((w - 1) / 2);
        up = reach(h / 2); dn = reach((h - 1) / 2);
      end else begin
        rt = reach(w - 1); lf = rt;
        up = reach(h - 1); dn = up;
      end
      ofs_len = 0;
      for (int y = -dn; y <= up; y++) begin
        for (int x = -lf; x <= rt; x++) begin
          ax = x < 0 ? -x : x;
          ay = y < 0 ? -y : y;
          k = ((x * x + y * y) << 6) | (ax > ay ? ax : ay);
          j = ofs_len;
          while (j > 0 && ofs_key[j-1] > k) begin
            ofs_key[j] = ofs_key[j-1];
            ofs_dx[j] = ofs_dx[j-1];
            ofs_dy[j] = ofs_dy[j-1];
            j--;
          end
          ofs_key[j] = k;
          ofs_dx[j] = x;
          ofs_dy[j] = y;
          ofs_len++;
        end
      end
      ofs_stale = 0;
    endfunction

    function void unlink(int o);
      int n, p;
      n = nxt[o];
      p = prv[o];
      prv[n] = p;
      nxt[p] = n;
      nxt[o] = o;
      prv[o] = o;
    endfunction

    function void push_ack();
      hit_t r;
      r.found_id = 0;
      r.none_found = 1;
      r.last = 1;
      pending.push_back(r);
    endfunction

    function void note_item(gbnq_pkg::opcode_t op, logic [9:0] id, logic signed [9:0] cx,
                            logic signed [9:0] cy, logic [7:0] rng, logic [6:0] cap_in);
      int w, h, lim, cap, cnt, xw, yw, head, nd, first;
      hit_t r;
      w = eff_w();
      h = eff_h();
      if (op == gbnq_pkg::OP_QUERY) begin
        lim = 2 * rng * rng;
        cap = cap_in > gbnq_pkg::MAX_RESULTS ? gbnq_pkg::MAX_RESULTS : cap_in;
        cnt = 0;
        if (ofs_stale) sort_offsets();
        for (int i = 0; i < ofs_len && cnt < cap; i++) begin
          if ((ofs_key[i] >> 6) > lim) break;
          xw = cx + ofs_dx[i];
          yw = cy + ofs_dy[i];
          if (xw < 0) begin
            if (!wrap_reg) continue;
            xw += w;
          end else if (xw >= w) begin
            if (!wrap_reg) continue;
            xw -= w;
          end
          if (yw < 0) begin
            if (!wrap_reg) continue;
            yw += h;
          end else if (yw >= h) begin
            if (!wrap_reg) continue;
            yw -= h;
          end
          if (xw < 0 || xw >= w || yw < 0 || yw >= h) continue;
          head = gbnq_pkg::NUM_OBJECTS + xw * gbnq_pkg::GRID_H + yw;
          nd = nxt[head];
          while (nd != head && nd < gbnq_pkg::NUM_OBJECTS && cnt < cap) begin
            r.found_id = 10'(nd);
            r.none_found = 0;
            r.last = 0;
            pending.push_back(r);
            cnt++;
            nd = nxt[nd];
          end
        end
        if (cnt == 0) push_ack();
        else pending[pending.size()-1].last = 1;
        return;
      end
      if (op == gbnq_pkg::OP_MOVE || op == gbnq_pkg::OP_REMOVE) begin
        unlink(id);
        if (op == gbnq_pkg::OP_MOVE && cx >= 0 && cx < w && cy >= 0 && cy < h) begin
          head = gbnq_pkg::NUM_OBJECTS + cx * gbnq_pkg::GRID_H + cy;
          first = nxt[head];
          nxt[id] = first;
          prv[id] = head;
          prv[first] = id;
          nxt[head] = id;
        end
      end
      push_ack();
    endfunction

    function void check(logic [9:0] fid, logic nf, logic lst);
      hit_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result id=%0d none=%0d last=%0d", $time, fid, nf, lst);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (fid !== e.found_id || nf !== e.none_found || lst !== e.last) begin
        $display("%0t: mismatch exp id=%0d none=%0d last=%0d, got id=%0d none=%0d last=%0d",
                 $time, e.found_id, e.none_found, e.last, fid, nf, lst);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 0;
  logic              rst_n = 0;
  logic              start = 0;
  logic              busy;
  logic [1:0]        in_opcode = 0;
  logic [9:0]        in_object_id = 0;
  logic signed [9:0] in_cell_x = 0;
  logic signed [9:0] in_cell_y = 0;
  logic [7:0]        in_search_range = 0;
  logic [6:0]        in_max_found = 0;
  logic              out_valid;
  logic [9:0]        out_found_id;
  logic              out_none_found;
  logic              out_last;
  logic              cfg_we = 0;
  logic [1:0]        cfg_index = 0;
  logic [6:0]        cfg_wdata = 0;

  neighbour_scoreboard sb = new();
  int stall_cycles = 0;
  bit steady = 0;

  grid_bucket_neighbor_query_top uut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check(out_found_id, out_none_found, out_last);
      if (start && !busy)
        sb.note_item(in_opcode, in_object_id, in_cell_x, in_cell_y,
                     in_search_range, in_max_found);
      if (out_valid || (start && !busy)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles > STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // called at a rising edge; returns at the edge where the transfer happens
  task automatic send_item(gbnq_pkg::opcode_t op, int id, int cx, int cy, int rng, int cap);
    int gap;
    bit ok;
    if (steady) gap = 0;
    else if ($urandom_range(0, 9) == 0) gap = $urandom_range(8, 60);
    else gap = $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    in_opcode <= op;
    in_object_id <= 10'(id);
    in_cell_x <= 10'(cx);
    in_cell_y <= 10'(cy);
    in_search_range <= 8'(rng);
    in_max_found <= 7'(cap);
    do begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
    end while (!ok);
  endtask

  task automatic drain();
    bit ok;
    start <= 0;
    while (sb.pending.size() > 0) @(posedge clk);
    do begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
    end while (!ok);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.configure(idx, val);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_items(int count);
    int w, h, kind, cx, cy, id, rng, cap;
    w = sb.eff_w();
    h = sb.eff_h();
    for (int i = 0; i < count; i++) begin
      if (i % 10 == 0) steady = $urandom_range(0, 2) == 0;
      kind = $urandom_range(0, 9);
      id = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 47);
      if ($urandom_range(0, 7) == 0) begin
        cx = $urandom_range(0, 1023) - 512;
        cy = $urandom_range(0, 1023) - 512;
      end else begin
        cx = $urandom_range(0, w - 1);
        cy = $urandom_range(0, h - 1);
      end
      rng = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4);
      cap = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 12);
      if (kind < 5) send_item(gbnq_pkg::OP_MOVE, id, cx, cy, rng, cap);
      else if (kind < 6) send_item(gbnq_pkg::OP_REMOVE, id, cx, cy, rng, cap);
      else if (kind < 9)
        send_item(gbnq_pkg::OP_QUERY, $urandom_range(0, 1023), cx, cy, rng, cap);
      else send_item(OP_SPARE, id, cx, cy, rng, cap);
    end
    steady = 0;
  endtask

  initial begin
    sb.clear_state();
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: corners, off-grid, removal, spare opcode, query extremes
    send_item(gbnq_pkg::OP_MOVE, 0, 0, 0, 0, 1);
    send_item(gbnq_pkg::OP_MOVE, 1023, 63, 63, 0, 1);
    send_item(gbnq_pkg::OP_MOVE, 5, 0, 0, 0, 1);
    send_item(gbnq_pkg::OP_MOVE, 6, 1, 1, 0, 1);
    send_item(gbnq_pkg::OP_MOVE, 7, -1, 0, 0, 1);
    send_item(gbnq_pkg::OP_MOVE, 8, 511, -512, 0, 1);
    send_item(gbnq_pkg::OP_MOVE, 9, 63, 0, 0, 1);
    send_item(gbnq_pkg::OP_QUERY, 0, 0, 0, 0, 64);
    send_item(gbnq_pkg::OP_QUERY, 0, 0, 0, 1, 64);
    send_item(gbnq_pkg::OP_QUERY, 0, 0, 0, 1, 0);
    send_item(gbnq_pkg::OP_QUERY, 1023, 0, 0, 255, 127);
    send_item(gbnq_pkg::OP_QUERY, 0, -512, 511, 255, 127);
    send_item(gbnq_pkg::OP_QUERY, 0, 40, 40, 2, 5);
    send_item(OP_SPARE, 6, 2, 2, 0, 1);
    send_item(gbnq_pkg::OP_REMOVE, 5, 0, 0, 0, 1);
    send_item(gbnq_pkg::OP_REMOVE, 5, 0, 0, 0, 1);
    send_item(gbnq_pkg::OP_MOVE, 6, 62, 62, 0, 1);
    send_item(gbnq_pkg::OP_QUERY, 0, 63, 63, 1, 2);
    send_item(gbnq_pkg::OP_QUERY, 0, 10, 10, 0, 1);
    random_items(25);

    // wrap with tiny grid: objects beyond the new size stay hidden
    drain();
    write_reg(gbnq_pkg::CFG_GRID_WIDTH, 7'd3);
    write_reg(gbnq_pkg::CFG_GRID_HEIGHT, 7'd2);
    write_reg(gbnq_pkg::CFG_WRAP_MODE, 7'd1);
    send_item(gbnq_pkg::OP_QUERY, 0, -1, -1, 3, 64);
    send_item(gbnq_pkg::OP_QUERY, 0, 511, -512, 2, 64);
    random_items(22);

    drain();
    write_reg(gbnq_pkg::CFG_GRID_WIDTH, 7'd1);
    write_reg(gbnq_pkg::CFG_GRID_HEIGHT, 7'd1);
    random_items(15);

    // out-of-range sizes are clamped
    drain();
    write_reg(gbnq_pkg::CFG_GRID_WIDTH, 7'd0);
    write_reg(gbnq_pkg::CFG_GRID_HEIGHT, 7'd127);
    write_reg(gbnq_pkg::CFG_WRAP_MODE, 7'd0);
    random_items(18);

    drain();
    write_reg(gbnq_pkg::CFG_GRID_WIDTH, 7'd64);
    write_reg(gbnq_pkg::CFG_GRID_HEIGHT, 7'd64);
    write_reg(gbnq_pkg::CFG_WRAP_MODE, 7'd1);
    send_item(gbnq_pkg::OP_QUERY, 0, 0, 0, 255, 127);
    random_items(25);

    drain();
    write_reg(gbnq_pkg::CFG_GRID_WIDTH, 7'd7);
    write_reg(gbnq_pkg::CFG_GRID_HEIGHT, 7'd9);
    write_reg(gbnq_pkg::CFG_WRAP_MODE, 7'd0);
    random_items(25);

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
